[hw/rtl/mwmul_pkg.sv]
package mwmul_pkg;

	localparam int LIMB_W  = 32;
	localparam int INDEX_W = 8;

	typedef logic [LIMB_W-1:0] limb_t;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_MUL  = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [INDEX_W-1:0] index;
		limb_t              a_limb;
		limb_t              b_limb;
	} req_t;

	typedef struct packed {
		limb_t product_limb;
		logic  read_valid;
	} rsp_t;

	// control from the row sequencer into the multiply-accumulate pipe
	typedef struct packed {
		logic issue;
		logic first_row;
		logic clear_carry;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic wr_en;
	} mac_sts_t;

endpackage

[hw/rtl/mwmul_mac.sv]
module mwmul_mac import mwmul_pkg::*; #(
	parameter int PW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mac_ctl_t              ctl,
	input  logic [PW-1:0]         addr,
	input  limb_t                 a_op,
	input  limb_t                 b_op,
	input  limb_t                 acc_in,
	output mac_sts_t              sts,
	output logic [PW-1:0]         wr_addr,
	output limb_t                 wr_data,
	output limb_t                 carry
);

	logic                    v_s1, v_s2, v_s3;
	logic                    first_s1;
	logic [PW-1:0]           addr_s1, addr_s2, addr_s3;
	logic [2*LIMB_W-1:0]     prod_s2;
	limb_t                   acc_s2;
	logic [2*LIMB_W-1:0]     sum_s3;
	logic [2*LIMB_W-1:0]     total;
	limb_t                   carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1 sees the memory read data, s2 holds the product, s3 folds in the carry
	always_ff @(posedge clk) begin
		first_s1 <= ctl.first_row;
		addr_s1  <= addr;
		addr_s2  <= addr_s1;
		addr_s3  <= addr_s2;
		prod_s2  <= 64'(a_op) * 64'(b_op);
		// the first row starts from an empty accumulator
		acc_s2   <= first_s1 ? '0 : acc_in;
		sum_s3   <= prod_s2 + 64'(acc_s2);
	end

	assign total = sum_s3 + 64'(carry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (ctl.clear_carry) begin
			carry_q <= '0;
		end else if (v_s3) begin
			carry_q <= total[2*LIMB_W-1:LIMB_W];
		end
	end

	assign sts.busy  = v_s1 | v_s2 | v_s3;
	assign sts.wr_en = v_s3;
	assign wr_addr   = addr_s3;
	assign wr_data   = total[LIMB_W-1:0];
	assign carry     = carry_q;

endmodule

[hw/rtl/multiword_integer_multiplier.sv]
// Unsigned multiword multiplier, operands of LIMB_COUNT 32-bit limbs, lsb limb first.
// Request channel (req_valid/req_stall/req) carries one word per item:
//   load  - writes a_limb and b_limb at index; ignored when index >= LIMB_COUNT
//   mul   - forms the 2*LIMB_COUNT limb product into the product memory
//   read  - returns the product limb at index; read_valid low when out of range
// Every item gives exactly one response word (rsp_valid/rsp_stall/rsp), passed through
// a pending stage and then the response register; non-read items answer with zeros.
// Loads and reads are taken one per cycle while no multiply runs and the response
// path is free. A multiply keeps req_stall high while one 32x32 multiply-accumulate
// pipeline walks the rows of the schoolbook product, one limb per cycle, and each
// row ends with a drain of the pipe before its carry limb is written.
// A product limb must be written by a multiply before it is read, and a multiply
// must only use loaded operand limbs; memories are not cleared at reset.
// Reset empties the response register and returns the sequencer to idle.
// While the receiver stalls, one more item is taken and held behind the
// response register, then req_stall rises until the response moves on.
module multiword_integer_multiplier import mwmul_pkg::*; #(
	parameter int LIMB_COUNT = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW         = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
	localparam int PROD_COUNT = 2 * LIMB_COUNT;
	localparam int PW         = $clog2(PROD_COUNT);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROWA,
		S_MAC,
		S_DRAIN
	} state_t;

	state_t        state;
	logic [AW-1:0] row_q, col_q;

	limb_t a_mem [LIMB_COUNT];
	limb_t b_mem [LIMB_COUNT];
	limb_t p_mem [PROD_COUNT];
	limb_t a_rd_q, b_rd_q, p_rd_q;

	logic          req_acc;
	logic          rsp_full_stall;
	logic          load_we;
	logic          read_hit;
	logic          mul_go;
	logic          pend_valid_s1, pend_rd_s1, pend_move;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          p_re, p_we, carry_we;
	logic [PW-1:0] mac_addr, p_raddr, p_waddr, carry_addr;
	limb_t         p_wdata;

	mac_ctl_t      mac_ctl;
	mac_sts_t      mac_sts;
	logic [PW-1:0] mac_wr_addr;
	limb_t         mac_wr_data;
	limb_t         mac_carry;

	assign req_acc        = req_valid & ~req_stall;
	assign rsp_full_stall = rsp_valid_q & rsp_stall;
	assign pend_move      = pend_valid_s1 & ~rsp_full_stall;
	assign req_stall      = (state != S_IDLE) | (pend_valid_s1 & rsp_full_stall);

	assign load_we  = req_acc & (req.func == FUNC_LOAD) & (int'(req.index) < LIMB_COUNT);
	assign read_hit = (req.func == FUNC_READ) & (int'(req.index) < PROD_COUNT);
	assign mul_go   = req_acc & (req.func == FUNC_MUL);

	// product memory addressing
	assign mac_addr   = PW'(row_q) + PW'(col_q);
	assign carry_addr = PW'(row_q) + PW'(LIMB_COUNT);
	assign carry_we   = (state == S_DRAIN) & ~mac_sts.busy;
	assign p_re       = (req_acc & read_hit) | (state == S_MAC);
	assign p_raddr    = (state == S_IDLE) ? PW'(req.index) : mac_addr;
	assign p_we       = mac_sts.wr_en | carry_we;
	assign p_waddr    = carry_we ? carry_addr : mac_wr_addr;
	assign p_wdata    = carry_we ? mac_carry : mac_wr_data;

	always_ff @(posedge clk) begin
		if (load_we) begin
			a_mem[AW'(req.index)] <= req.a_limb;
			b_mem[AW'(req.index)] <= req.b_limb;
		end
		a_rd_q <= a_mem[row_q];
		b_rd_q <= b_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			p_mem[p_waddr] <= p_wdata;
		end
		if (p_re) begin
			p_rd_q <= p_mem[p_raddr];
		end
	end

	assign mac_ctl.issue       = (state == S_MAC);
	assign mac_ctl.first_row   = (row_q == '0);
	assign mac_ctl.clear_carry = (state == S_ROWA);

	mwmul_mac #(
		.PW(PW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.addr    (mac_addr),
		.a_op    (a_rd_q),
		.b_op    (b_rd_q),
		.acc_in  (p_rd_q),
		.sts     (mac_sts),
		.wr_addr (mac_wr_addr),
		.wr_data (mac_wr_data),
		.carry   (mac_carry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state         <= S_IDLE;
			row_q         <= '0;
			col_q         <= '0;
			pend_valid_s1 <= 1'b0;
			pend_rd_s1    <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			case (state)
				S_IDLE: begin
					if (mul_go) begin
						row_q <= '0;
						col_q <= '0;
						state <= S_ROWA;
					end
				end
				// a_rd_q picks up the new row limb during this cycle
				S_ROWA: begin
					state <= S_MAC;
				end
				S_MAC: begin
					if (col_q == AW'(LIMB_COUNT - 1)) begin
						col_q <= '0;
						state <= S_DRAIN;
					end else begin
						col_q <= col_q + AW'(1);
					end
				end
				// the next row reads limbs this row writes, so let the pipe empty
				S_DRAIN: begin
					if (!mac_sts.busy) begin
						if (row_q == AW'(LIMB_COUNT - 1)) begin
							state <= S_IDLE;
						end else begin
							row_q <= row_q + AW'(1);
							state <= S_ROWA;
						end
					end
				end
				default: begin
					state <= S_IDLE;
				end
			endcase

			if (req_acc) begin
				pend_valid_s1 <= 1'b1;
				pend_rd_s1    <= read_hit;
			end else if (pend_move) begin
				pend_valid_s1 <= 1'b0;
			end

			if (pend_move) begin
				rsp_valid_q        <= 1'b1;
				rsp_q.product_limb <= pend_rd_s1 ? p_rd_q : '0;
				rsp_q.read_valid   <= pend_rd_s1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(mac_sts.wr_en && carry_we))
		else $error("pipeline write and carry write collide");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_IDLE) |-> !mac_sts.busy)
		else $error("sequencer idle with work in the pipe");

	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.func == FUNC_MUL) |=> (state == S_ROWA))
		else $error("multiply accepted but sequencer did not start");

	a_zero_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.read_valid) |-> (rsp_q.product_limb == '0))
		else $error("non-read response carries data");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import mwmul_pkg::*;

	localparam int LIMB_COUNT = 128;
	localparam int ITEMS_TARGET = 900;
	localparam int SETTLE_CYCLES = 40;
	// worst case is roughly twenty multiplies, each of which stalls the request side
	localparam logic [31:0] CYCLE_LIMIT = 32'd2_000_000;
	// the spare function code, which the block ignores
	localparam func_t FUNC_SPARE = func_t'(2'b11);

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	logic [31:0] cycle_count = '0;
	int unsigned mismatches = 0;
	int unsigned gap_left;
	int unsigned stall_left;

	req_t req_backlog[$];
	rsp_t expected_rsp_words[$];

	limb_t op_a[LIMB_COUNT];
	limb_t op_b[LIMB_COUNT];
	limb_t product_limbs[2*LIMB_COUNT];

	multiword_integer_multiplier #(
		.LIMB_COUNT(LIMB_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// both sides run without idling while bits 9:8 of the cycle count are zero
	function automatic int unsigned pick_wait();
		if (cycle_count[9:8] == 2'b00) begin
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	function automatic limb_t rand_limb();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] load_index();
		if ($urandom_range(0, 9) == 0) begin
			return 8'($urandom_range(LIMB_COUNT, 255));
		end
		return 8'($urandom_range(0, LIMB_COUNT - 1));
	endfunction

	// schoolbook product of the two operand copies, one row of carries at a time
	function automatic void form_product();
		logic [63:0] t;
		limb_t carry;
		for (int k = 0; k < 2*LIMB_COUNT; k++) begin
			product_limbs[k] = '0;
		end
		for (int i = 0; i < LIMB_COUNT; i++) begin
			carry = '0;
			for (int j = 0; j < LIMB_COUNT; j++) begin
				t = 64'(op_a[i]) * 64'(op_b[j]) + 64'(product_limbs[i+j]) + 64'(carry);
				product_limbs[i+j] = t[31:0];
				carry = t[63:32];
			end
			product_limbs[i+LIMB_COUNT] = carry;
		end
	endfunction

	function automatic void apply_request(req_t w);
		rsp_t r;
		r = '0;
		case (w.func)
			FUNC_LOAD: begin
				if (int'(w.index) < LIMB_COUNT) begin
					op_a[w.index] = w.a_limb;
					op_b[w.index] = w.b_limb;
				end
			end
			FUNC_MUL: begin
				form_product();
			end
			FUNC_READ: begin
				if (int'(w.index) < 2*LIMB_COUNT) begin
					r.product_limb = product_limbs[w.index];
					r.read_valid = 1'b1;
				end
			end
			default: ;
		endcase
		expected_rsp_words.push_back(r);
	endfunction

	function automatic void report_mismatch(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s): expected limb %h valid %b, got limb %h valid %b",
				what, want.product_limb, want.read_valid, got.product_limb, got.read_valid);
		end
	endfunction

	function automatic void check_word(rsp_t got);
		rsp_t want;
		if (expected_rsp_words.size() == 0) begin
			report_mismatch("word with nothing expected", '0, got);
		end else begin
			want = expected_rsp_words.pop_front();
			if (got.product_limb !== want.product_limb) begin
				report_mismatch("product_limb", want, got);
			end else if (got.read_valid !== want.read_valid) begin
				report_mismatch("read_valid", want, got);
			end
		end
	endfunction

	task automatic queue_word(input func_t f, input logic [7:0] idx, input limb_t a,
		input limb_t b);
		req_t w;
		w.func = f;
		w.index = idx;
		w.a_limb = a;
		w.b_limb = b;
		req_backlog.push_back(w);
	endtask

	// request driver, predicts each word as it is taken
	always @(posedge clk or negedge arst_n) begin : req_side
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				apply_request(req);
			end
			if (!req_valid || !req_stall) begin
				if (gap_left != 0) begin
					req_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (req_backlog.size() != 0) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
					gap_left <= pick_wait();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor with random back-pressure after each word
	always @(posedge clk or negedge arst_n) begin : rsp_side
		int unsigned hold;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			hold = stall_left;
			if (rsp_valid && !rsp_stall) begin
				check_word(rsp);
				hold = pick_wait();
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				stall_left <= hold - 1;
			end else begin
				rsp_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned pick;
		arst_n = 1'b0;

		// every operand limb must be written before the first multiply
		for (int i = 0; i < LIMB_COUNT; i++) begin
			queue_word(FUNC_LOAD, 8'(i), '1, '1);
		end
		queue_word(FUNC_LOAD, 8'(LIMB_COUNT), 32'h1234_5678, 32'h9abc_def0);
		queue_word(FUNC_LOAD, 8'd255, '0, '1);
		queue_word(FUNC_SPARE, 8'd255, '1, '1);
		queue_word(FUNC_MUL, '0, '0, '0);
		queue_word(FUNC_READ, 8'd0, '0, '0);
		queue_word(FUNC_READ, 8'd1, '1, '1);
		queue_word(FUNC_READ, 8'(LIMB_COUNT - 1), '0, '0);
		queue_word(FUNC_READ, 8'(LIMB_COUNT), '0, '0);
		queue_word(FUNC_READ, 8'd255, '0, '0);
		// one zero limb in a, top limb of b at its msb only
		queue_word(FUNC_LOAD, 8'd0, '0, '1);
		queue_word(FUNC_LOAD, 8'(LIMB_COUNT - 1), '1, 32'h8000_0000);
		queue_word(FUNC_MUL, 8'd255, '1, '1);
		queue_word(FUNC_READ, 8'd0, '0, '0);
		queue_word(FUNC_READ, 8'(LIMB_COUNT - 1), '0, '0);
		queue_word(FUNC_READ, 8'd254, '0, '0);
		queue_word(FUNC_READ, 8'd255, '0, '0);

		// rounds of operand updates, a multiply, then mostly reads
		while (req_backlog.size() < ITEMS_TARGET) begin
			n = $urandom_range(1, 40);
			repeat (n) begin
				if ($urandom_range(0, 19) == 0) begin
					queue_word(FUNC_SPARE, 8'($urandom), $urandom, $urandom);
				end else begin
					queue_word(FUNC_LOAD, load_index(), rand_limb(), rand_limb());
				end
			end
			queue_word(FUNC_MUL, 8'($urandom), $urandom, $urandom);
			n = $urandom_range(40, 80);
			repeat (n) begin
				pick = $urandom_range(0, 19);
				if (pick < 16) begin
					queue_word(FUNC_READ, 8'($urandom), $urandom, $urandom);
				end else if (pick < 18) begin
					queue_word(FUNC_LOAD, load_index(), rand_limb(), rand_limb());
				end else begin
					queue_word(FUNC_SPARE, 8'($urandom), $urandom, $urandom);
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req_valid || expected_rsp_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_rsp_words.size() != 0) begin
			$display("%0d expected words never arrived", expected_rsp_words.size());
		end
		if (mismatches == 0 && expected_rsp_words.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
